/* rtl/tpm_pkg.sv */
package tpm_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned N_COORD   = 6;
    localparam int unsigned TOL_W     = 8;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned IN_DATA_W = COORD_W * (N_COORD + 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef logic [N_COORD-1:0][COORD_W-1:0] t_coords;

    typedef struct packed {
        logic [COORD_W-1:0] picture;
        t_coords            coords;
    } t_rec;

    // one slot of the compare chain: a record in flight and its running verdict
    typedef struct packed {
        logic valid;
        logic hit;
        t_rec rec;
    } t_stage;

endpackage

/* rtl/tpm_store.sv */
module tpm_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tpm_pkg::t_rec   i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tpm_pkg::t_stage o_stage
);
    import tpm_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;
    logic r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_re;
        end
    end

    assign o_stage.valid = r_rvalid;
    assign o_stage.hit   = 1'b1;
    assign o_stage.rec   = r_rdata;

endmodule

/* rtl/tpm_cell.sv */
module tpm_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [tpm_pkg::COORD_W-1:0] i_query,
    input  logic [tpm_pkg::TOL_W-1:0]   i_tol,
    input  tpm_pkg::t_stage             i_stage,
    output tpm_pkg::t_stage             o_stage
);
    import tpm_pkg::*;

    logic [COORD_W-1:0]  r_q;
    t_stage              r_stage;
    logic signed [COORD_W+1:0] w_diff;
    logic signed [COORD_W+1:0] w_tol;
    logic                w_near;

    // exact difference, two guard bits so nothing wraps
    assign w_diff = {{2{r_q[COORD_W-1]}}, r_q}
                  - {{2{i_stage.rec.coords[IDX][COORD_W-1]}}, i_stage.rec.coords[IDX]};
    assign w_tol  = {{(COORD_W+2-TOL_W){1'b0}}, i_tol};
    assign w_near = (w_diff <= w_tol) && (w_diff >= -w_tol);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_query;
        end
        r_stage.rec <= i_stage.rec;
        r_stage.hit <= i_stage.hit & w_near;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

/* rtl/tolerant_triple_point_match.sv */
// Channel  | Dir | Fields (low bit up)
// s (in)   | in  | tdata: from_x, from_y, node_x, node_y, to_x, to_y, picture_in; tuser: cmd
// m (out)  | out | tdata: picture_out; tuser: found
// cfg      | in  | wdata: tolerance (8 bits, reset 1)
//
// Clear and append complete as they are accepted. During a query the table memory
// reads one record a cycle into a row of six compare cells, one per coordinate,
// and the scan stops issuing once the first hit leaves the chain.
// Reset (synchronous, active low) empties the table and sets tolerance to 1.
// A finished result is held in the output register while the next request is
// taken; a query waits at its end while that register is still full.
module tolerant_triple_point_match #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,   // tolerance
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [223:0]  i_s_tdata,     // from_x, from_y, node_x, node_y, to_x, to_y, picture_in
    input  logic [1:0]    i_s_tuser,     // cmd
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [31:0]   o_m_tdata,     // picture_out
    output logic          o_m_tuser      // found
);
    import tpm_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PW = 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_addr,  n_addr;
    logic [PW-1:0]      r_pending, n_pending;
    logic               r_hit, n_hit;
    logic [COORD_W-1:0] r_pic, n_pic;
    logic [TOL_W-1:0]   r_tol;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [COORD_W-1:0] r_out_pic, n_out_pic;

    logic    w_accept;
    logic    w_issue;
    logic    w_we;
    logic    w_load;
    t_rec    w_in_rec;
    t_stage  w_chain [N_COORD+1];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = w_accept && (i_s_tuser == CMD_QUERY);
    assign w_we       = w_accept && (i_s_tuser == CMD_APPEND)
                        && (r_count < CW'(TABLE_DEPTH));
    assign w_issue    = (r_state == S_SCAN) && !r_hit && (r_addr < r_count);

    assign w_in_rec.coords  = i_s_tdata[COORD_W*N_COORD-1:0];
    assign w_in_rec.picture = i_s_tdata[IN_DATA_W-1:COORD_W*N_COORD];

    tpm_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_in_rec),
        .i_re    (w_issue),
        .i_raddr (r_addr[AW-1:0]),
        .o_stage (w_chain[0])
    );

    // one cell per coordinate; each holds its query coordinate
    for (genvar g = 0; g < N_COORD; g++) begin : g_cell
        tpm_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load),
            .i_query (i_s_tdata[COORD_W*g +: COORD_W]),
            .i_tol   (r_tol),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_pic       = r_pic;
        n_pending   = r_pending + PW'(w_issue) - PW'(w_chain[N_COORD].valid);
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_found = r_out_found;
        n_out_pic   = r_out_pic;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_s_tuser)
                        CMD_CLEAR: n_count = '0;
                        CMD_APPEND: begin
                            if (w_we) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_QUERY: begin
                            n_addr  = '0;
                            n_hit   = 1'b0;
                            n_pic   = '0;
                            n_state = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_addr = r_addr + CW'(1);
                end
                // first hit to leave the chain wins; later ones drain unused
                if (w_chain[N_COORD].valid && w_chain[N_COORD].hit && !r_hit) begin
                    n_hit = 1'b1;
                    n_pic = w_chain[N_COORD].rec.picture;
                end
                if (!w_issue && r_pending == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_hit;
                    n_out_pic   = r_pic;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_W'(1);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_hit       <= n_hit;
        r_pic       <= n_pic;
        r_out_found <= n_out_found;
        r_out_pic   <= n_out_pic;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pic;
    assign o_m_tuser  = r_out_found;

endmodule
